>>> src/upe_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// upe_pkg
// Shared types, constants and character helpers for the URI percent encoder.
// ----------------------------------------------------------------------------
package upe_pkg;

   // classified item passed from the front part to the back part
   typedef struct packed {
      logic [7:0] data;
      logic       encode;
      logic       eot;
   } entry_type;

   // output character position within an encoded item
   typedef logic [1:0] phase_type;

   localparam phase_type PHASE_PERCENT = 2'd0;
   localparam phase_type PHASE_HI      = 2'd1;
   localparam phase_type PHASE_LO      = 2'd2;

   // queue geometry
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   // safe set: the first SAFE_COUNT_COMPONENT entries are the component set
   localparam int SAFE_COUNT_FULL      = 20;
   localparam int SAFE_COUNT_COMPONENT = 9;

   typedef logic [7:0] safe_set_type [SAFE_COUNT_FULL];

   localparam safe_set_type SAFE_SET = '{
      8'h2D, 8'h5F, 8'h2E, 8'h21, 8'h7E, 8'h2A, 8'h27, 8'h28, 8'h29, 8'h3B,
      8'h2C, 8'h2F, 8'h3F, 8'h3A, 8'h40, 8'h26, 8'h3D, 8'h2B, 8'h24, 8'h23
   };

   localparam logic [7:0] CHAR_PERCENT = 8'h25;

   // group lengths for a lead byte (continuation bytes still expected)
   typedef logic [1:0] group_left_type;

   localparam group_left_type GROUP_TWO   = 2'd1;
   localparam group_left_type GROUP_THREE = 2'd2;
   localparam group_left_type GROUP_FOUR  = 2'd3;

   // letter, digit or safe-set member passes unchanged
   function automatic logic passes_plain(input logic [7:0] c, input logic full_mode);
      logic hit;
      hit = ((c >= 8'h30) && (c <= 8'h39)) ||
            ((c >= 8'h41) && (c <= 8'h5A)) ||
            ((c >= 8'h61) && (c <= 8'h7A));
      for (int i = 0; i < SAFE_COUNT_FULL; i++) begin
         if ((full_mode || (i < SAFE_COUNT_COMPONENT)) && (SAFE_SET[i] == c)) begin
            hit = 1'b1;
         end
      end
      return hit;
   endfunction

   // lowercase hex digit for one nibble
   function automatic logic [7:0] hex_char(input logic [3:0] nib);
      logic [7:0] ch;
      if (nib < 4'd10) begin
         ch = 8'h30 + {4'd0, nib};
      end else begin
         ch = 8'h57 + {4'd0, nib};
      end
      return ch;
   endfunction

endpackage
`default_nettype wire

>>> src/upe_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// upe_front
// Accepts input bytes, tracks the UTF-8 group and decides pass or encode.
// ----------------------------------------------------------------------------
module upe_front (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               full_mode,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic [7:0]         req_in_byte,
   input  wire logic               req_end_of_text,
   input  wire logic               push_ready,
   output logic                    push_valid,
   output upe_pkg::entry_type      push_entry
);

   upe_pkg::group_left_type group_left_ff;
   upe_pkg::group_left_type group_left_in;
   logic                    accept;
   logic                    encode;

   assign req_ready  = push_ready;
   assign push_valid = req_valid;
   assign accept     = req_valid && push_ready;

   // classify the byte and work out the next group count
   always_comb begin
      group_left_in = group_left_ff;
      encode        = 1'b1;
      if (group_left_ff != 2'd0) begin
         group_left_in = group_left_ff - 2'd1;
      end else if (!req_in_byte[7]) begin
         encode = !upe_pkg::passes_plain(req_in_byte, full_mode);
      end else begin
         priority if ((req_in_byte & 8'hE0) == 8'hC0) begin
            group_left_in = upe_pkg::GROUP_TWO;
         end else if ((req_in_byte & 8'hF0) == 8'hE0) begin
            group_left_in = upe_pkg::GROUP_THREE;
         end else begin
            group_left_in = upe_pkg::GROUP_FOUR;
         end
      end
      if (req_end_of_text) begin
         group_left_in = 2'd0;
      end
   end

   assign push_entry.data   = req_in_byte;
   assign push_entry.encode = encode;
   assign push_entry.eot    = req_end_of_text;

   // group counter
   always_ff @(posedge clock) begin
      if (reset) begin
         group_left_ff <= 2'd0;
      end else if (accept) begin
         group_left_ff <= group_left_in;
      end
   end

endmodule
`default_nettype wire

>>> src/upe_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// upe_queue
// Short queue of classified items between the front and the back part.
// ----------------------------------------------------------------------------
module upe_queue (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push_valid,
   output logic                    push_ready,
   input  wire upe_pkg::entry_type push_entry,
   output logic                    pop_valid,
   input  wire logic               pop,
   output upe_pkg::entry_type      pop_entry
);

   upe_pkg::entry_type                entries_ff [upe_pkg::QUEUE_DEPTH];
   logic [upe_pkg::QUEUE_PTR_W-1:0]   wr_ptr_ff;
   logic [upe_pkg::QUEUE_PTR_W-1:0]   rd_ptr_ff;
   logic [upe_pkg::QUEUE_CNT_W-1:0]   count_ff;
   logic [upe_pkg::QUEUE_CNT_W-1:0]   count_in;
   logic                              do_push;
   logic                              do_pop;

   assign push_ready = (count_ff != upe_pkg::QUEUE_CNT_W'(upe_pkg::QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_entry  = entries_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop && pop_valid;

   // occupancy
   always_comb begin
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   // pointers and count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule
`default_nettype wire

>>> src/upe_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// upe_back
// Emits one output character per cycle while rsp_ready is high: the byte itself or '%' and two hex.
// ----------------------------------------------------------------------------
module upe_back (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               pop_valid,
   output logic                    pop,
   input  wire upe_pkg::entry_type pop_entry,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic [7:0]              rsp_out_char,
   output logic                    rsp_run_last,
   output logic                    rsp_text_done
);

   logic                cur_valid_ff;
   upe_pkg::entry_type  cur_ff;
   upe_pkg::phase_type  phase_ff;
   logic                last;
   logic                take;

   // last character of the current item
   assign last = !cur_ff.encode || (phase_ff == upe_pkg::PHASE_LO);
   assign take = !cur_valid_ff || (rsp_ready && last);
   assign pop  = take && pop_valid;

   // character select
   always_comb begin
      rsp_out_char = cur_ff.data;
      if (cur_ff.encode) begin
         unique case (phase_ff)
            upe_pkg::PHASE_PERCENT: rsp_out_char = upe_pkg::CHAR_PERCENT;
            upe_pkg::PHASE_HI:      rsp_out_char = upe_pkg::hex_char(cur_ff.data[7:4]);
            default:                rsp_out_char = upe_pkg::hex_char(cur_ff.data[3:0]);
         endcase
      end
   end

   assign rsp_valid     = cur_valid_ff;
   assign rsp_run_last  = last;
   assign rsp_text_done = last && cur_ff.eot;

   // current item and character position
   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         phase_ff     <= upe_pkg::PHASE_PERCENT;
      end else if (take) begin
         cur_valid_ff <= pop_valid;
         phase_ff     <= upe_pkg::PHASE_PERCENT;
      end else if (rsp_ready) begin
         phase_ff     <= phase_ff + 2'd1;
      end
   end

   // item payload
   always_ff @(posedge clock) begin
      if (pop) begin
         cur_ff <= pop_entry;
      end
   end

endmodule
`default_nettype wire

>>> src/uri_percent_encoder.sv
`default_nettype none
// ----------------------------------------------------------------------------
// uri_percent_encoder
// Percent-encodes a stream of UTF-8 bytes into a stream of ASCII characters.
// ----------------------------------------------------------------------------
//  channel   ports                                        direction
//  req       req_valid/ready, req_in_byte, req_end_of_text   in
//  rsp       rsp_valid/ready, rsp_out_char, rsp_run_last,    out
//            rsp_text_done
//  csr       csr_wr_en, csr_wr_data (full_uri_mode)          in
//
//  A plain byte yields one character, an encoded byte three, one per cycle
//  while rsp_ready is high; the single-character output port sets the rate.
//  A new byte is taken every cycle while the two-entry queue has room.
//  Reset clears the group count, the queue and the output, and sets full mode.
//  Either side may stall; the queue lets the input run ahead of the output.
// ----------------------------------------------------------------------------
module uri_percent_encoder (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_wr_en,
   input  wire logic        csr_wr_data,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_in_byte,
   input  wire logic        req_end_of_text,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [7:0]       rsp_out_char,
   output logic             rsp_run_last,
   output logic             rsp_text_done
);

   logic               full_mode_ff;
   logic               push_valid;
   logic               push_ready;
   upe_pkg::entry_type push_entry;
   logic               pop_valid;
   logic               pop;
   upe_pkg::entry_type pop_entry;

   // mode register
   always_ff @(posedge clock) begin
      if (reset) begin
         full_mode_ff <= 1'b1;
      end else if (csr_wr_en) begin
         full_mode_ff <= csr_wr_data;
      end
   end

   upe_front u_front (
      .clock           (clock),
      .reset           (reset),
      .full_mode       (full_mode_ff),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_in_byte     (req_in_byte),
      .req_end_of_text (req_end_of_text),
      .push_ready      (push_ready),
      .push_valid      (push_valid),
      .push_entry      (push_entry)
   );

   upe_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry),
      .pop_valid  (pop_valid),
      .pop        (pop),
      .pop_entry  (pop_entry)
   );

   upe_back u_back (
      .clock         (clock),
      .reset         (reset),
      .pop_valid     (pop_valid),
      .pop           (pop),
      .pop_entry     (pop_entry),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_out_char  (rsp_out_char),
      .rsp_run_last  (rsp_run_last),
      .rsp_text_done (rsp_text_done)
   );

endmodule
`default_nettype wire

>>> tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for uri_percent_encoder. Bytes of UTF-8 text go in on
// the req channel from a queue. A local model of the encoder predicts the
// characters each accepted byte should produce. The rsp channel is checked
// character by character, in order. Both sides idle at random, and the
// full/component mode changes between phases while the block is idle.
// ----------------------------------------------------------------------------
module testbench;

   localparam int CYCLE_LIMIT = 200000;

   // one pending input item
   typedef struct {
      logic [7:0] in_byte;
      logic       eot;
   } text_byte_type;

   // one expected output character
   typedef struct {
      logic [7:0] ch;
      logic       run_last;
      logic       text_done;
   } enc_char_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       csr_wr_en = 1'b0;
   logic       csr_wr_data = 1'b0;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [7:0] req_in_byte = 8'h00;
   logic       req_end_of_text = 1'b0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [7:0] rsp_out_char;
   logic       rsp_run_last;
   logic       rsp_text_done;

   text_byte_type pending_bytes[$];
   enc_char_type  expected_chars[$];

   // model state: mode register copy and open utf-8 group count
   logic       uri_full_mode = 1'b1;
   logic [1:0] group_left = 2'd0;

   int error_count = 0;
   int cycle_count = 0;
   int send_gap_max = 6;
   int recv_stall_max = 6;
   int send_gap = 0;
   int recv_stall = 0;

   uri_percent_encoder dut (
      .clock           (clock),
      .reset           (reset),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_in_byte     (req_in_byte),
      .req_end_of_text (req_end_of_text),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_out_char    (rsp_out_char),
      .rsp_run_last    (rsp_run_last),
      .rsp_text_done   (rsp_text_done)
   );

   // clock
   initial begin
      forever #5 clock = ~clock;
   end

   task automatic report_mismatch(input string msg);
      $display("mismatch at cycle %0d: %s", cycle_count, msg);
      error_count++;
   endtask

   // letter, digit, or member of the active safe set
   function automatic logic is_unreserved(input logic [7:0] c, input logic full_mode);
      string safe_chars;
      int    n;
      logic  hit;
      safe_chars = "-_.!~*'();,/?:@&=+$#";
      n = full_mode ? 20 : 9;
      hit = (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
      for (int i = 0; i < n; i++) begin
         if (safe_chars[i] == c) hit = 1'b1;
      end
      return hit;
   endfunction

   function automatic logic [7:0] hex_digit(input logic [3:0] nib);
      string digits;
      digits = "0123456789abcdef";
      return digits[nib];
   endfunction

   // append one expected character at the tail
   task automatic expect_char(input logic [7:0] ch, input logic run_last,
                              input logic text_done);
      enc_char_type c;
      c.ch = ch;
      c.run_last = run_last;
      c.text_done = text_done;
      expected_chars.insert(expected_chars.size(), c);
   endtask

   // predict the characters for one accepted byte and advance the group count
   task automatic encode_byte(input logic [7:0] b, input logic eot);
      logic encode;
      if (group_left != 2'd0) begin
         encode = 1'b1;
         group_left = group_left - 2'd1;
      end else if (!b[7]) begin
         encode = !is_unreserved(b, uri_full_mode);
      end else begin
         encode = 1'b1;
         if (b[7:5] == 3'b110) group_left = 2'd1;
         else if (b[7:4] == 4'b1110) group_left = 2'd2;
         else group_left = 2'd3;
      end
      if (encode) begin
         expect_char(8'h25, 1'b0, 1'b0);
         expect_char(hex_digit(b[7:4]), 1'b0, 1'b0);
         expect_char(hex_digit(b[3:0]), 1'b1, eot);
      end else begin
         expect_char(b, 1'b1, eot);
      end
      if (eot) group_left = 2'd0;
   endtask

   // driver: present queued items with a random gap after each
   always @(posedge clock) begin
      text_byte_type item;
      if (reset) begin
         req_valid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_valid && req_ready) encode_byte(req_in_byte, req_end_of_text);
         if (!req_valid || req_ready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (pending_bytes.size() != 0) begin
               item = pending_bytes.pop_front();
               req_valid <= 1'b1;
               req_in_byte <= item.in_byte;
               req_end_of_text <= item.eot;
               send_gap = $urandom_range(0, send_gap_max);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor: random stall after each item, compare against the oldest expectation
   always @(posedge clock) begin
      enc_char_type exp_char;
      if (reset) begin
         rsp_ready <= 1'b0;
         recv_stall = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_chars.size() == 0) begin
               report_mismatch($sformatf("unexpected char 0x%02h", rsp_out_char));
            end else begin
               exp_char = expected_chars.pop_front();
               if (rsp_out_char !== exp_char.ch)
                  report_mismatch($sformatf("out_char 0x%02h, want 0x%02h",
                                            rsp_out_char, exp_char.ch));
               if (rsp_run_last !== exp_char.run_last)
                  report_mismatch($sformatf("run_last %b, want %b (char 0x%02h)",
                                            rsp_run_last, exp_char.run_last, exp_char.ch));
               if (rsp_text_done !== exp_char.text_done)
                  report_mismatch($sformatf("text_done %b, want %b (char 0x%02h)",
                                            rsp_text_done, exp_char.text_done, exp_char.ch));
            end
            recv_stall = $urandom_range(0, recv_stall_max);
            rsp_ready <= (recv_stall == 0);
         end else if (!rsp_ready) begin
            if (recv_stall > 0) recv_stall--;
            rsp_ready <= (recv_stall == 0);
         end
      end
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   task automatic push_byte(input logic [7:0] b, input logic eot);
      text_byte_type item;
      item.in_byte = b;
      item.eot = eot;
      pending_bytes.insert(pending_bytes.size(), item);
   endtask

   // write the mode register; only called with the block idle
   task automatic set_uri_mode(input logic full_mode);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= full_mode;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      uri_full_mode = full_mode;
   endtask

   // hold until every queued item is taken and every expected char has come
   task automatic wait_drained();
      while (pending_bytes.size() != 0 || req_valid || expected_chars.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // one random string: mostly well-formed utf-8, some truncated groups and noise
   task automatic push_random_text(output int count);
      logic [7:0] text[$];
      int         len;
      int         kind;
      int         cont;
      len = $urandom_range(1, 10);
      for (int k = 0; k < len; k++) begin
         kind = $urandom_range(0, 99);
         cont = 0;
         if (kind < 55) begin
            text.insert(text.size(), 8'($urandom_range(8'h20, 8'h7e)));
         end else if (kind < 65) begin
            text.insert(text.size(), 8'hc0 | 8'($urandom_range(0, 31)));
            cont = 1;
         end else if (kind < 73) begin
            text.insert(text.size(), 8'he0 | 8'($urandom_range(0, 15)));
            cont = 2;
         end else if (kind < 80) begin
            text.insert(text.size(), 8'hf0 | 8'($urandom_range(0, 7)));
            cont = 3;
         end else if (kind < 90) begin
            text.insert(text.size(), 8'($urandom_range(0, 127)));
         end else begin
            text.insert(text.size(), 8'($urandom_range(0, 255)));
         end
         // broken group now and then
         if (cont > 0 && $urandom_range(0, 9) == 0) cont = $urandom_range(0, cont - 1);
         for (int j = 0; j < cont; j++)
            text.insert(text.size(), 8'h80 | 8'($urandom_range(0, 63)));
      end
      foreach (text[i]) push_byte(text[i], i == text.size() - 1);
      count = text.size();
   endtask

   // stimulus and end of run
   initial begin
      int phase_count;
      int text_len;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed, full uri mode
      set_uri_mode(1'b1);
      push_byte("A", 1'b0);
      push_byte("z", 1'b0);
      push_byte("0", 1'b0);
      push_byte("9", 1'b0);
      push_byte("-", 1'b0);
      push_byte("#", 1'b0);
      push_byte(" ", 1'b0);
      push_byte(8'h00, 1'b0);
      push_byte(8'h7f, 1'b0);
      // malformed lead opens a group of four; continuations encode whatever they hold
      push_byte(8'hff, 1'b0);
      push_byte(8'h00, 1'b0);
      push_byte(8'h41, 1'b0);
      push_byte(8'h7f, 1'b0);
      push_byte(8'hc3, 1'b0);
      push_byte(8'ha9, 1'b0);
      push_byte(8'he2, 1'b0);
      push_byte(8'h82, 1'b0);
      push_byte(8'hac, 1'b0);
      // unfinished group dropped by end of text
      push_byte(8'hf0, 1'b0);
      push_byte(8'h9f, 1'b1);
      push_byte("a", 1'b1);
      wait_drained();

      // directed, component mode
      set_uri_mode(1'b0);
      push_byte("#", 1'b0);
      push_byte("~", 1'b0);
      push_byte(8'h80, 1'b1);
      push_byte("(", 1'b1);
      wait_drained();

      // random phases, alternating mode and idling pattern
      for (int phase = 0; phase < 6; phase++) begin
         set_uri_mode(phase[0]);
         send_gap_max = (phase == 1 || phase == 4) ? 0 : 6;
         recv_stall_max = (phase == 2 || phase == 4) ? 0 : 6;
         phase_count = 0;
         while (phase_count < 64) begin
            push_random_text(text_len);
            phase_count += text_len;
         end
         wait_drained();
      end

      repeat (20) @(posedge clock);
      if (error_count == 0 && expected_chars.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

>>> files.f
src/upe_pkg.sv
src/upe_front.sv
src/upe_queue.sv
src/upe_back.sv
src/uri_percent_encoder.sv
tb/testbench.sv
